// ----- sv/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types and constants of the triangle plane clipper
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

    localparam int N_ATTR     = 6;
    localparam int DATA_W     = 32;
    localparam int RAM_DEPTH  = 30;   // five rows of six attributes
    localparam int RAM_AW     = 5;

    // configuration register indexes
    localparam logic [2:0] CFG_POINT_X  = 3'd0;
    localparam logic [2:0] CFG_POINT_Y  = 3'd1;
    localparam logic [2:0] CFG_POINT_Z  = 3'd2;
    localparam logic [2:0] CFG_NORMAL_X = 3'd3;
    localparam logic [2:0] CFG_NORMAL_Y = 3'd4;
    localparam logic [2:0] CFG_NORMAL_Z = 3'd5;
    localparam logic [2:0] CFG_COUNT    = 3'd6;

    localparam logic [31:0] NORMAL_Z_RESET = 32'h0001_0000;

    // vertex store rows: rows 0 to 2 hold the input vertices, ROW_E0 and ROW_E1 the edge points
    localparam logic [2:0] ROW_E0 = 3'd3;
    localparam logic [2:0] ROW_E1 = 3'd4;

    localparam logic [5:0] DIV_LAST = 6'd32;   // 33 quotient bits

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DMUL,
        ST_DSAT,
        ST_WR,
        ST_PLAN,
        ST_ELOAD,
        ST_ARD,
        ST_EMUL,
        ST_DINIT,
        ST_DIV,
        ST_EWR,
        ST_OREAD,
        ST_OSHOW
    } tpc_state_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_go;
        logic       mul_edge;
        logic [1:0] axis;
        logic       acc_first;
        logic       acc_add;
        logic       dist_wr;
        logic [1:0] slot;
        logic       ram_we;
        logic       wsrc_edge;
        logic [2:0] row;
        logic [2:0] attr;
        logic [1:0] dsel;
        logic       da_load;
        logic       db_load;
        logic       a_load;
        logic       b_load;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        logic [2:0] out_idx;
    } tpc_cmd_t;

    typedef struct packed {
        logic [2:0] dist_neg;
    } tpc_stat_t;

endpackage

`default_nettype wire

// ----- sv/tpc_ram.sv -----
// ----------------------------------------------------------------------------
// tpc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/tpc_dp.sv -----
// ----------------------------------------------------------------------------
// tpc_dp
// datapath: plane registers, distance multiplier, vertex store, edge divider
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [31:0]      cfg_data,
    input  wire logic [191:0]     s_tdata,
    input  wire tpc_pkg::tpc_cmd_t cmd,
    output tpc_pkg::tpc_stat_t    stat,
    output logic      [191:0]     m_tdata
);

    localparam int PROD_W   = 65;
    localparam int TERM_W   = PROD_W - FRAC_BITS;
    localparam int ACC_W    = TERM_W + 2;
    localparam int RAM_AW_L = tpc_pkg::RAM_AW;

    logic signed [31:0]       cfg_reg [6];
    logic        [31:0]       vin_reg [6];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [31:0]       dist_reg [3];
    logic signed [31:0]       da_reg;
    logic signed [31:0]       db_reg;
    logic        [31:0]       a_reg;
    logic        [31:0]       b_reg;
    logic                     neg_reg;
    logic        [32:0]       rem_reg;
    logic        [32:0]       quo_reg;
    logic        [32:0]       den_reg;
    logic        [31:0]       out_reg [6];

    logic signed [32:0]          mul_a;
    logic signed [31:0]          mul_b;
    logic signed [TERM_W-1:0]    term;
    logic        [31:0]          sat_val;
    logic        [ACC_W-32:0]    acc_hi;
    logic        [PROD_W-1:0]    mag;
    logic        [33:0]          trial;
    logic        [33:0]          trial_diff;
    logic                        trial_ge;
    logic        [31:0]          edge_val;
    logic        [31:0]          ram_wdata;
    logic        [31:0]          ram_rdata;
    logic        [RAM_AW_L-1:0]  ram_addr;

    // plane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                cfg_reg[i] <= '0;
            end
            cfg_reg[tpc_pkg::CFG_NORMAL_Z] <= tpc_pkg::NORMAL_Z_RESET;
        end else if (cfg_valid && (cfg_index < tpc_pkg::CFG_COUNT)) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // shared multiplier operands
    always_comb begin
        if (cmd.mul_edge) begin
            mul_a = $signed({b_reg[31], b_reg}) - $signed({a_reg[31], a_reg});
            mul_b = da_reg;
        end else begin
            mul_a = $signed({vin_reg[cmd.axis][31], vin_reg[cmd.axis]})
                  - $signed({cfg_reg[{1'b0, cmd.axis}][31], cfg_reg[{1'b0, cmd.axis}]});
            mul_b = cfg_reg[tpc_pkg::CFG_NORMAL_X + {1'b0, cmd.axis}];
        end
    end

    assign term = $signed(prod_reg[PROD_W-1:FRAC_BITS]);

    // saturate the distance sum to 32 bit
    assign acc_hi = acc_reg[ACC_W-1:31];
    always_comb begin
        if ((&acc_hi) || !(|acc_hi)) begin
            sat_val = acc_reg[31:0];
        end else if (acc_reg[ACC_W-1]) begin
            sat_val = 32'h8000_0000;
        end else begin
            sat_val = 32'h7fff_ffff;
        end
    end

    // restoring divider step
    assign mag        = prod_reg[PROD_W-1] ? 65'(-prod_reg) : prod_reg;
    assign trial      = {rem_reg, quo_reg[32]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};
    assign edge_val   = a_reg + (neg_reg ? (~quo_reg[31:0] + 32'd1) : quo_reg[31:0]);

    assign ram_addr  = RAM_AW_L'({cmd.row, 2'b00}) + RAM_AW_L'({cmd.row, 1'b0})
                     + RAM_AW_L'(cmd.attr);
    assign ram_wdata = cmd.wsrc_edge ? edge_val : vin_reg[cmd.attr];

    tpc_ram #(
        .WIDTH (32),
        .DEPTH (tpc_pkg::RAM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            for (int i = 0; i < 6; i++) begin
                vin_reg[i] <= s_tdata[i*32 +: 32];
            end
        end
        if (cmd.mul_go) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_first) begin
            acc_reg <= ACC_W'(term);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
        if (cmd.dist_wr) begin
            dist_reg[cmd.slot] <= sat_val;
        end
        if (cmd.da_load) begin
            da_reg <= dist_reg[cmd.dsel];
        end
        if (cmd.db_load) begin
            db_reg <= dist_reg[cmd.dsel];
        end
        if (cmd.a_load) begin
            a_reg <= ram_rdata;
        end
        if (cmd.b_load) begin
            b_reg <= ram_rdata;
        end
        if (cmd.div_init) begin
            neg_reg <= prod_reg[PROD_W-1];
            rem_reg <= 33'(mag[63:33]);
            quo_reg <= mag[32:0];
            den_reg <= 33'($signed({da_reg[31], da_reg}) - $signed({db_reg[31], db_reg}));
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[32:0] : trial[32:0];
            quo_reg <= {quo_reg[31:0], trial_ge};
        end
        if (cmd.out_load) begin
            out_reg[cmd.out_idx] <= ram_rdata;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            stat.dist_neg[i] = dist_reg[i][31];
        end
    end

    assign m_tdata = {out_reg[5], out_reg[4], out_reg[3],
                      out_reg[2], out_reg[1], out_reg[0]};

endmodule

`default_nettype wire

// ----- sv/tpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpc_ctrl
// controller: sequences distance, store writes, edge division and output
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic                    m_tuser,
    output logic                    m_tlast,
    input  wire tpc_pkg::tpc_stat_t stat,
    output tpc_pkg::tpc_cmd_t       cmd
);

    tpc_pkg::tpc_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] slot_reg, slot_next;
    logic       edge_reg, edge_next;
    logic [2:0] attr_reg, attr_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] nemit_reg, nemit_next;
    logic       two_reg, two_next;
    logic [2:0] rows_reg [6];
    logic [2:0] rows_next [6];
    logic [1:0] ea_reg [2];
    logic [1:0] ea_next [2];
    logic [1:0] eb_reg [2];
    logic [1:0] eb_next [2];

    logic [1:0] slot_eff;
    logic [2:0] p_rows [6];
    logic [1:0] p_ea [2];
    logic [1:0] p_eb [2];
    logic [2:0] p_nemit;
    logic       p_two;

    assign slot_eff = (slot_reg == 2'd3) ? 2'd0 : slot_reg;

    // clip plan from the inside flags of the three vertices
    always_comb begin
        p_rows  = '{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0};
        p_ea    = '{2'd0, 2'd0};
        p_eb    = '{2'd0, 2'd0};
        p_nemit = 3'd0;
        p_two   = 1'b0;
        unique case (~stat.dist_neg)
            3'b111: begin
                p_nemit = 3'd3;
            end
            3'b001, 3'b010, 3'b100: begin
                p_nemit = 3'd3;
                unique case (~stat.dist_neg)
                    3'b001:  begin p_ea = '{2'd0, 2'd0}; p_eb = '{2'd1, 2'd2}; end
                    3'b010:  begin p_ea = '{2'd1, 2'd1}; p_eb = '{2'd0, 2'd2}; end
                    default: begin p_ea = '{2'd2, 2'd2}; p_eb = '{2'd0, 2'd1}; end
                endcase
                p_rows = '{{1'b0, p_ea[0]}, tpc_pkg::ROW_E0, tpc_pkg::ROW_E1,
                           3'd0, 3'd0, 3'd0};
            end
            3'b011, 3'b101, 3'b110: begin
                p_nemit = 3'd6;
                p_two   = 1'b1;
                unique case (~stat.dist_neg)
                    3'b011:  begin p_ea = '{2'd0, 2'd1}; p_eb = '{2'd2, 2'd2}; end
                    3'b101:  begin p_ea = '{2'd0, 2'd2}; p_eb = '{2'd1, 2'd1}; end
                    default: begin p_ea = '{2'd1, 2'd2}; p_eb = '{2'd0, 2'd0}; end
                endcase
                p_rows = '{{1'b0, p_ea[0]}, {1'b0, p_ea[1]}, tpc_pkg::ROW_E0,
                           {1'b0, p_ea[1]}, tpc_pkg::ROW_E0, tpc_pkg::ROW_E1};
            end
            default: begin
                p_nemit = 3'd0;
            end
        endcase
    end

    // next state and sequencing counters
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        edge_next  = edge_reg;
        attr_next  = attr_reg;
        pos_next   = pos_reg;
        nemit_next = nemit_reg;
        two_next   = two_reg;
        rows_next  = rows_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        unique case (state_reg)
            tpc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tpc_pkg::ST_DMUL;
                    cnt_next   = '0;
                end
            end
            tpc_pkg::ST_DMUL: begin
                if (cnt_reg == 6'd3) begin
                    state_next = tpc_pkg::ST_DSAT;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            tpc_pkg::ST_DSAT: begin
                state_next = tpc_pkg::ST_WR;
                cnt_next   = '0;
            end
            tpc_pkg::ST_WR: begin
                if (cnt_reg == 6'd5) begin
                    if (slot_eff == 2'd2) begin
                        slot_next  = '0;
                        state_next = tpc_pkg::ST_PLAN;
                    end else begin
                        slot_next  = slot_eff + 2'd1;
                        state_next = tpc_pkg::ST_IDLE;
                    end
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            tpc_pkg::ST_PLAN: begin
                rows_next  = p_rows;
                ea_next    = p_ea;
                eb_next    = p_eb;
                nemit_next = p_nemit;
                two_next   = p_two;
                edge_next  = 1'b0;
                pos_next   = '0;
                cnt_next   = '0;
                if (p_nemit == 3'd0) begin
                    state_next = tpc_pkg::ST_IDLE;
                end else if (~stat.dist_neg == 3'b111) begin
                    state_next = tpc_pkg::ST_OREAD;
                end else begin
                    state_next = tpc_pkg::ST_ELOAD;
                end
            end
            tpc_pkg::ST_ELOAD: begin
                if (cnt_reg == 6'd1) begin
                    state_next = tpc_pkg::ST_ARD;
                    attr_next  = '0;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            tpc_pkg::ST_ARD: begin
                if (cnt_reg == 6'd2) begin
                    state_next = tpc_pkg::ST_EMUL;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            tpc_pkg::ST_EMUL: begin
                state_next = tpc_pkg::ST_DINIT;
            end
            tpc_pkg::ST_DINIT: begin
                state_next = tpc_pkg::ST_DIV;
                cnt_next   = '0;
            end
            tpc_pkg::ST_DIV: begin
                if (cnt_reg == tpc_pkg::DIV_LAST) begin
                    state_next = tpc_pkg::ST_EWR;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            tpc_pkg::ST_EWR: begin
                cnt_next = '0;
                if (attr_reg == 3'd5) begin
                    if (edge_reg) begin
                        state_next = tpc_pkg::ST_OREAD;
                    end else begin
                        edge_next  = 1'b1;
                        state_next = tpc_pkg::ST_ELOAD;
                    end
                end else begin
                    attr_next  = attr_reg + 3'd1;
                    state_next = tpc_pkg::ST_ARD;
                end
            end
            tpc_pkg::ST_OREAD: begin
                if (cnt_reg == 6'd6) begin
                    state_next = tpc_pkg::ST_OSHOW;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            tpc_pkg::ST_OSHOW: begin
                if (m_tready) begin
                    cnt_next = '0;
                    if (pos_reg == nemit_reg - 3'd1) begin
                        state_next = tpc_pkg::ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 3'd1;
                        state_next = tpc_pkg::ST_OREAD;
                    end
                end
            end
            default: begin
                state_next = tpc_pkg::ST_IDLE;
            end
        endcase
    end

    // commands to the datapath and handshake outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tuser  = two_reg && (pos_reg >= 3'd3);
        m_tlast  = (pos_reg == nemit_reg - 3'd1);
        unique case (state_reg)
            tpc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            tpc_pkg::ST_DMUL: begin
                cmd.axis      = cnt_reg[1:0];
                cmd.mul_go    = (cnt_reg != 6'd3);
                cmd.acc_first = (cnt_reg == 6'd1);
                cmd.acc_add   = (cnt_reg != 6'd0);
            end
            tpc_pkg::ST_DSAT: begin
                cmd.dist_wr = 1'b1;
                cmd.slot    = slot_eff;
            end
            tpc_pkg::ST_WR: begin
                cmd.ram_we = 1'b1;
                cmd.row    = {1'b0, slot_eff};
                cmd.attr   = cnt_reg[2:0];
            end
            tpc_pkg::ST_ELOAD: begin
                cmd.dsel    = (cnt_reg == 6'd0) ? ea_reg[edge_reg] : eb_reg[edge_reg];
                cmd.da_load = (cnt_reg == 6'd0);
                cmd.db_load = (cnt_reg == 6'd1);
            end
            tpc_pkg::ST_ARD: begin
                cmd.row    = (cnt_reg == 6'd0) ? {1'b0, ea_reg[edge_reg]}
                                               : {1'b0, eb_reg[edge_reg]};
                cmd.attr   = attr_reg;
                cmd.a_load = (cnt_reg == 6'd1);
                cmd.b_load = (cnt_reg == 6'd2);
            end
            tpc_pkg::ST_EMUL: begin
                cmd.mul_go   = 1'b1;
                cmd.mul_edge = 1'b1;
            end
            tpc_pkg::ST_DINIT: begin
                cmd.div_init = 1'b1;
            end
            tpc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            tpc_pkg::ST_EWR: begin
                cmd.ram_we    = 1'b1;
                cmd.wsrc_edge = 1'b1;
                cmd.row       = edge_reg ? tpc_pkg::ROW_E1 : tpc_pkg::ROW_E0;
                cmd.attr      = attr_reg;
            end
            tpc_pkg::ST_OREAD: begin
                cmd.row      = rows_reg[pos_reg];
                cmd.attr     = (cnt_reg == 6'd6) ? 3'd0 : cnt_reg[2:0];
                cmd.out_load = (cnt_reg != 6'd0);
                cmd.out_idx  = 3'(cnt_reg - 6'd1);
            end
            tpc_pkg::ST_OSHOW: begin
                m_tvalid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            slot_reg  <= '0;
            edge_reg  <= 1'b0;
            attr_reg  <= '0;
            pos_reg   <= '0;
            nemit_reg <= '0;
            two_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
            edge_reg  <= edge_next;
            attr_reg  <= attr_next;
            pos_reg   <= pos_next;
            nemit_reg <= nemit_next;
            two_reg   <= two_next;
        end
    end

    always_ff @(posedge aclk) begin
        rows_reg <= rows_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
    end

endmodule

`default_nettype wire

// ----- sv/triangle_plane_clipper_core.sv -----
// ----------------------------------------------------------------------------
// triangle_plane_clipper_core
// clips a stream of triangles against one configurable plane
// ----------------------------------------------------------------------------
// usage:
//   vertices enter on the s_ channel, three per triangle, one transaction each
//   the user writes the plane (point and inside-pointing normal) on the cfg_ channel
//   only while the block is idle, unchecked by the block; cfg_ready is always high
//   clipped vertices leave on the m_ channel; m_tuser tells the output triangle
//   (0 first, 1 second) and m_tlast marks the last vertex of an input triangle
// sequence:
//   each vertex keeps the block busy through accept, multiply/accumulate steps
//   for the plane distance, saturation and six store writes
//   after a third vertex each new edge point is computed
//   by the 33-step shared restoring divider, one attribute at a time
//   each output vertex is read from the store, then shown as one transaction
//   an unclipped triangle goes from the plan straight to the output store reads
// reset: aresetn low clears the controller and loads the default plane
//   (origin, normal +z); the vertex store is not cleared
// stall: while m_tready is low the result holds and no vertex is accepted
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_plane_clipper_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // vertex input
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // vertex_x, vertex_y, vertex_z, tex_u, tex_v, tex_w
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // clipped vertex output
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [191:0] m_tdata,   // out_x, out_y, out_z, out_u, out_v, out_w
    output logic              m_tuser,   // triangle_index
    output logic              m_tlast    // last_of_run
);

    tpc_pkg::tpc_cmd_t  cmd;
    tpc_pkg::tpc_stat_t stat;

    // configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    tpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sv/tpc_checker.sv -----
// ----------------------------------------------------------------------------
// tpc_checker
// port-level checks of the clipper core
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [191:0] m_tdata,
    input wire logic         m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one vertex or one result at a time
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result shown");

    // a vertex keeps the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("block not busy after vertex");

    // run ends after its last vertex
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after last of run");

endmodule

bind triangle_plane_clipper_core tpc_checker u_tpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the triangle plane clipper core
// ----------------------------------------------------------------------------
// vertices go in on the s_ channel and the plane is set on the cfg_ channel
// a bit-exact plane clipper in the bench predicts the clipped vertices; table rows may type theirs in
// each m_ transaction is checked field by field against the oldest prediction
// a short table of triangles, then zero, rewritten and extreme planes, then random
// triangles under several planes, with random input gaps and random output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int SETTLE_CYCLES = 700;   // longest triangle with no output
    localparam int WDOG_LIMIT    = 5000;

    typedef logic signed [31:0] vtx_t [6];

    typedef struct packed {
        logic [191:0] data;
        logic         tri_idx;
        logic         last;
    } clip_vtx_t;

    // expected results of a directed row
    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_PASS,
        EXP_NONE
    } exp_kind_t;

    typedef struct {
        vtx_t      v [3];
        exp_kind_t kind;
    } tri_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;    // vertex_x, vertex_y, vertex_z, tex_u, tex_v, tex_w
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;    // out_x, out_y, out_z, out_u, out_v, out_w
    logic         m_tuser;    // triangle_index
    logic         m_tlast;    // last_of_run

    triangle_plane_clipper_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // clipper model: plane copy, vertex and distance slots, slot counter
    // ------------------------------------------------------------------------
    logic signed [31:0] plane_reg [6];
    vtx_t               tri_vtx [3];
    logic signed [31:0] tri_dist [3];
    int                 tri_slot;

    clip_vtx_t clipped_q [$];    // predictions waiting for their transaction

    int n_fail;
    int n_vtx_in;
    int n_vtx_out;
    int n_cfg;
    int n_tri_two;               // triangles split into two

    function automatic string attr_name(int j);
        case (j)
            0:       return "out_x";
            1:       return "out_y";
            2:       return "out_z";
            3:       return "out_u";
            4:       return "out_v";
            default: return "out_w";
        endcase
    endfunction

    function automatic logic [191:0] pack_vtx(vtx_t v);
        logic [191:0] d;
        for (int j = 0; j < 6; j++) d[32*j +: 32] = v[j];
        return d;
    endfunction

    // signed distance, each axis floored to the fixed point, sum saturated
    function automatic logic signed [31:0] plane_distance(vtx_t v);
        logic signed [32:0] diff;
        logic signed [65:0] prod;
        logic signed [67:0] sum;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            diff = v[i] - plane_reg[i];
            prod = diff * plane_reg[3+i];
            sum  = sum + (prod >>> 16);
        end
        if (sum > 68'sd2147483647)
            return 32'sh7fff_ffff;
        if (sum < -68'sd2147483648)
            return 32'sh8000_0000;
        return sum[31:0];
    endfunction

    // point on edge from inside slot ia to outside slot ib, quotient toward zero
    function automatic vtx_t edge_point(int ia, int ib);
        logic signed [33:0] denom;
        logic signed [32:0] delta;
        logic signed [96:0] num;
        logic signed [96:0] quo;
        vtx_t               e;
        denom = tri_dist[ia] - tri_dist[ib];
        if (denom < 1) denom = 1;
        for (int j = 0; j < 6; j++) begin
            delta = tri_vtx[ib][j] - tri_vtx[ia][j];
            num   = delta * tri_dist[ia];
            quo   = num / denom;
            e[j]  = tri_vtx[ia][j] + quo[31:0];
        end
        return e;
    endfunction

    function automatic void push_clipped(ref clip_vtx_t q [$], input vtx_t v,
                                         input logic tri_idx, input logic last);
        clip_vtx_t c;
        c.data    = pack_vtx(v);
        c.tri_idx = tri_idx;
        c.last    = last;
        q.push_back(c);
    endfunction

    // takes one accepted vertex, returns the vertices it makes
    function automatic void clip_vertex(vtx_t v, ref clip_vtx_t res [$]);
        int   ins [$];
        int   outs [$];
        vtx_t e0;
        vtx_t e1;
        int   s;
        s = (tri_slot > 2) ? 0 : tri_slot;
        tri_vtx[s]  = v;
        tri_dist[s] = plane_distance(v);
        if (s < 2) begin
            tri_slot = s + 1;
            return;
        end
        tri_slot = 0;
        for (int i = 0; i < 3; i++) begin
            if (tri_dist[i] >= 0) ins.push_back(i);
            else outs.push_back(i);
        end
        case (ins.size())
            3: begin
                for (int i = 0; i < 3; i++) push_clipped(res, tri_vtx[i], 1'b0, i == 2);
            end
            1: begin
                e0 = edge_point(ins[0], outs[0]);
                e1 = edge_point(ins[0], outs[1]);
                push_clipped(res, tri_vtx[ins[0]], 1'b0, 1'b0);
                push_clipped(res, e0, 1'b0, 1'b0);
                push_clipped(res, e1, 1'b0, 1'b1);
            end
            2: begin
                e0 = edge_point(ins[0], outs[0]);
                e1 = edge_point(ins[1], outs[0]);
                push_clipped(res, tri_vtx[ins[0]], 1'b0, 1'b0);
                push_clipped(res, tri_vtx[ins[1]], 1'b0, 1'b0);
                push_clipped(res, e0, 1'b0, 1'b0);
                push_clipped(res, tri_vtx[ins[1]], 1'b1, 1'b0);
                push_clipped(res, e0, 1'b1, 1'b0);
                push_clipped(res, e1, 1'b1, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one vertex transaction; use_model clear means the row carries its own results
    task automatic send_vertex(vtx_t v, bit use_model);
        clip_vtx_t res [$];
        int        gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= pack_vtx(v);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_vtx_in++;
        clip_vertex(v, res);
        if (use_model) begin
            foreach (res[k]) clipped_q.push_back(res[k]);
            if (res.size() == 6) n_tri_two++;
        end
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every predicted vertex, then for a triangle that emits nothing
    task automatic wait_idle();
        drop_valid();
        while (clipped_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // valid stays high so that writes can follow back to back
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        plane_reg[idx] = val;
        n_cfg++;
    endtask

    task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
        wait_idle();
        write_reg(tpc_pkg::CFG_POINT_X, px);
        write_reg(tpc_pkg::CFG_POINT_Y, py);
        write_reg(tpc_pkg::CFG_POINT_Z, pz);
        write_reg(tpc_pkg::CFG_NORMAL_X, nx);
        write_reg(tpc_pkg::CFG_NORMAL_Y, ny);
        write_reg(tpc_pkg::CFG_NORMAL_Z, nz);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(bit wide);
        if (wide) return $urandom;
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;   // +-8.0
    endfunction

    function automatic vtx_t rand_vtx(bit wide);
        vtx_t v;
        for (int j = 0; j < 3; j++) v[j] = rand_coord(wide);
        for (int j = 3; j < 6; j++) v[j] = $urandom;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------------
    int stall_left;
    int m_tready_hold;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready      <= 1'b1;
            m_tready_hold <= 0;
        end else if (m_tready_hold > 0) begin
            m_tready_hold <= m_tready_hold - 1;
        end else begin
            stall_left = $urandom_range(0, 99);
            if (stall_left < 60) begin
                m_tready      <= 1'b1;
                m_tready_hold <= $urandom_range(1, 25);
            end else if (stall_left < 92) begin
                m_tready      <= 1'b0;
                m_tready_hold <= $urandom_range(0, 3);
            end else begin
                m_tready      <= 1'b0;
                m_tready_hold <= $urandom_range(20, 60);
            end
        end
    end

    always @(posedge aclk) begin
        clip_vtx_t exp_v;
        if (aresetn && m_tvalid && m_tready) begin
            n_vtx_out++;
            if (clipped_q.size() == 0) begin
                $error("unexpected output vertex %h", m_tdata);
                n_fail++;
            end else begin
                exp_v = clipped_q.pop_front();
                for (int j = 0; j < 6; j++) begin
                    if (m_tdata[32*j +: 32] !== exp_v.data[32*j +: 32]) begin
                        $error("%s expected %h actual %h", attr_name(j),
                               exp_v.data[32*j +: 32], m_tdata[32*j +: 32]);
                        n_fail++;
                    end
                end
                if (m_tuser !== exp_v.tri_idx) begin
                    $error("triangle_index expected %0d actual %0d", exp_v.tri_idx, m_tuser);
                    n_fail++;
                end
                if (m_tlast !== exp_v.last) begin
                    $error("last_of_run expected %0d actual %0d", exp_v.last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    int idle_cycles;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // directed triangles, reset plane z >= 0
    // ------------------------------------------------------------------------
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    tri_row_t dir_rows [8];

    initial begin
        // all inside with the extremes, z on the plane counts as inside
        dir_rows[0].v[0] = '{SMAX, SMIN, 0, SMAX, SMIN, 32'sh0};
        dir_rows[0].v[1] = '{SMIN, SMAX, SMAX, SMIN, SMAX, -1};
        dir_rows[0].v[2] = '{0, -1, ONE, 32'sh5555_5555, 32'shaaaa_aaaa, SMAX};
        dir_rows[0].kind = EXP_PASS;
        // all outside, nothing comes out
        dir_rows[1].v[0] = '{ONE, ONE, -1, 1, 2, 3};
        dir_rows[1].v[1] = '{-ONE, ONE, SMIN, 4, 5, 6};
        dir_rows[1].v[2] = '{0, 0, -ONE, 7, 8, 9};
        dir_rows[1].kind = EXP_NONE;
        // one inside, first slot
        dir_rows[2].v[0] = '{0, 0, ONE, 0, 0, ONE};
        dir_rows[2].v[1] = '{ONE, 0, -ONE, ONE, 0, ONE};
        dir_rows[2].v[2] = '{0, ONE, -3*ONE, 0, ONE, ONE};
        dir_rows[2].kind = EXP_PREDICT;
        // one inside, last slot, negative attribute deltas
        dir_rows[3].v[0] = '{5*ONE, -2*ONE, -ONE/2, -ONE, 3*ONE, 0};
        dir_rows[3].v[1] = '{-ONE, 7*ONE, -7, SMIN, SMAX, -ONE};
        dir_rows[3].v[2] = '{0, 0, 3*ONE, ONE, ONE, ONE};
        dir_rows[3].kind = EXP_PREDICT;
        // two inside, outside vertex last
        dir_rows[4].v[0] = '{0, 0, ONE, 0, 0, ONE};
        dir_rows[4].v[1] = '{ONE, 0, 2*ONE, ONE, 0, ONE};
        dir_rows[4].v[2] = '{0, ONE, -ONE, 0, ONE, ONE};
        dir_rows[4].kind = EXP_PREDICT;
        // two inside, outside vertex first, extreme depths
        dir_rows[5].v[0] = '{SMAX, SMAX, SMIN, SMAX, SMIN, SMAX};
        dir_rows[5].v[1] = '{SMIN, SMIN, SMAX, SMIN, SMAX, SMIN};
        dir_rows[5].v[2] = '{3, -3, 0, 11, -11, 1};
        dir_rows[5].kind = EXP_PREDICT;
        // two inside, outside vertex in the middle, tiny distance
        dir_rows[6].v[0] = '{ONE, 2*ONE, 1, 100, 200, 300};
        dir_rows[6].v[1] = '{-ONE, -2*ONE, -1, -100, -200, -300};
        dir_rows[6].v[2] = '{0, 0, 0, SMAX, SMAX, SMAX};
        dir_rows[6].kind = EXP_PREDICT;
        // one inside on the plane itself, edge points collapse to it
        dir_rows[7].v[0] = '{SMIN, 0, -ONE, 1, 1, 1};
        dir_rows[7].v[1] = '{0, SMAX, 0, 2, 2, 2};
        dir_rows[7].v[2] = '{SMAX, 0, SMIN, 3, 3, 3};
        dir_rows[7].kind = EXP_PREDICT;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit   wide;
        int   n_rand;
        vtx_t t [3];

        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = tpc_pkg::CFG_POINT_X;
        cfg_data  = '0;
        n_fail    = 0;
        n_vtx_in  = 0;
        n_vtx_out = 0;
        n_cfg     = 0;
        n_tri_two = 0;
        idle_cycles = 0;
        tri_slot  = 0;
        for (int i = 0; i < 6; i++) plane_reg[i] = '0;
        plane_reg[tpc_pkg::CFG_NORMAL_Z] = tpc_pkg::NORMAL_Z_RESET;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // table rows: typed-in expectations where they are obvious
        foreach (dir_rows[r]) begin
            for (int k = 0; k < 3; k++)
                send_vertex(dir_rows[r].v[k], dir_rows[r].kind == EXP_PREDICT);
            if (dir_rows[r].kind == EXP_PASS)
                for (int k = 0; k < 3; k++)
                    push_clipped(clipped_q, dir_rows[r].v[k], 1'b0, k == 2);
        end

        // zero normal: every distance is zero, triangles pass unchanged
        set_plane($urandom, $urandom, $urandom, 0, 0, 0);
        for (int k = 0; k < 3; k++) send_vertex(rand_vtx(1'b1), 1'b1);

        // plane rewritten between the vertices of one triangle
        set_plane(0, 0, 0, ONE, 0, 0);
        send_vertex('{ONE, 0, 0, 1, 2, 3}, 1'b1);
        set_plane(0, 0, 0, -ONE, 0, 0);
        send_vertex('{ONE, ONE, 0, 4, 5, 6}, 1'b1);
        send_vertex('{-ONE, ONE, 0, 7, 8, 9}, 1'b1);

        // extreme planes, distances saturate both ways
        set_plane(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);
        for (int k = 0; k < 6; k++) send_vertex(rand_vtx(1'b1), 1'b1);
        set_plane(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
        for (int k = 0; k < 6; k++) send_vertex(rand_vtx(1'b1), 1'b1);

        // random part: planes through the working volume, a few wide triangles
        n_rand = 0;
        while (n_rand < 90) begin
            if (n_rand % 24 == 0) begin
                set_plane(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                          $urandom_range(0, 4*ONE) - 2*ONE,
                          $urandom_range(0, 4*ONE) - 2*ONE,
                          $urandom_range(0, 4*ONE) - 2*ONE);
            end
            // hold the sender until the block drains, once per phase
            if (n_rand % 24 == 12) begin
                drop_valid();
                while (clipped_q.size() != 0) @(posedge aclk);
            end
            wide = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 3; k++) t[k] = rand_vtx(wide);
            for (int k = 0; k < 3; k++) send_vertex(t[k], 1'b1);
            n_rand += 3;
        end

        drop_valid();
        while (clipped_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run: %0d vertices in, %0d vertices out, %0d split triangles",
                 n_vtx_in, n_vtx_out, n_tri_two);
        $display("run: %0d register writes over zero, extreme and random planes", n_cfg);
        if (n_fail == 0 && clipped_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
